// ----- hw/rtl/dqmv_pkg.sv -----
// Shared types, constants and float32 arithmetic helpers for the int8 dequant matvec row block.
// No dependencies; imported by every module of the block.
package dqmv_pkg;

    localparam int MAX_COLUMNS = 2048;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int OUTQ_DEPTH  = 8;
    localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);

    localparam logic [1:0]  REG_COLUMNS   = 2'd0;
    localparam logic [1:0]  REG_ROWS      = 2'd1;
    localparam logic [1:0]  REG_FIRST_ROW = 2'd2;
    localparam logic        REQ_LOAD      = 1'b0;
    localparam logic        REQ_WEIGHT    = 1'b1;
    localparam logic [7:0]  CODE_BIAS     = 8'h80;
    localparam logic [31:0] FP_ZERO       = 32'h0000_0000;
    localparam logic [31:0] FP_QNAN       = 32'h7FC0_0000;

    // front stage -> multiply/accumulate stage
    typedef struct packed {
        logic        vld;
        logic        clr;
        logic        fin;
        logic [7:0]  biased;
        logic [31:0] x;
        logic [31:0] scale;
        logic [31:0] offset;
        logic [15:0] rnum;
        logic        last;
    } dqmv_s1_t;

    // finished row sums -> output stage
    typedef struct packed {
        logic        vld;
        logic [31:0] dot;
        logic [31:0] sum;
        logic [31:0] scale;
        logic [31:0] offset;
        logic [15:0] rnum;
        logic        last;
    } dqmv_end_t;

    function automatic logic [31:0] u8_to_fp(input logic [7:0] u);
        logic [2:0]  msb;
        logic [4:0]  sh;
        logic [22:0] frac;
        msb = '0;
        for (int i = 0; i < 8; i++) begin
            if (u[i]) msb = 3'(i);
        end
        sh   = 5'd23 - {2'b0, msb};
        frac = 23'({15'b0, u} << sh);
        if (u == 8'd0) return FP_ZERO;
        return {1'b0, 8'(8'd127 + {5'b0, msb}), frac};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               sgn;
        logic [7:0]         ea, eb;
        logic [23:0]        ma, mb;
        logic [47:0]        p, pn;
        logic [5:0]         msb;
        logic signed [11:0] e;
        logic [11:0]        sh;
        logic [97:0]        sv;
        logic [23:0]        m;
        logic               g, st, inc;
        logic [30:0]        r;
        logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [31:0]        res;
        sgn    = a[31] ^ b[31];
        ea     = a[30:23];
        eb     = b[30:23];
        a_nan  = (ea == 8'hFF) && (a[22:0] != '0);
        b_nan  = (eb == 8'hFF) && (b[22:0] != '0);
        a_inf  = (ea == 8'hFF) && (a[22:0] == '0);
        b_inf  = (eb == 8'hFF) && (b[22:0] == '0);
        a_zero = (a[30:0] == '0);
        b_zero = (b[30:0] == '0);
        ma     = {ea != 8'd0, a[22:0]};
        mb     = {eb != 8'd0, b[22:0]};
        p      = ma * mb;
        msb    = '0;
        for (int i = 0; i < 48; i++) begin
            if (p[i]) msb = 6'(i);
        end
        pn = p << (6'd47 - msb);
        e  = $signed({6'b0, msb}) + $signed({4'b0, (ea == 8'd0) ? 8'd1 : ea})
             + $signed({4'b0, (eb == 8'd0) ? 8'd1 : eb}) - 12'sd173;
        m  = pn[47:24];
        g  = pn[23];
        st = |pn[22:0];
        if (e <= 12'sd0) begin
            // subnormal result: denormalize with sticky
            sh = 12'(12'sd1 - e);
            if (sh > 12'd50) begin
                m  = '0;
                g  = 1'b0;
                st = 1'b1;
            end else begin
                sv = {pn, 50'b0} >> sh;
                m  = sv[97:74];
                g  = sv[73];
                st = |sv[72:0];
            end
            e = '0;
        end
        inc = g & (st | m[0]);
        r   = {e[7:0], m[22:0]} + 31'(inc);
        if (e >= 12'sd255) res = {sgn, 8'hFF, 23'b0};
        else               res = {sgn, r};
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) res = FP_QNAN;
        else if (a_inf || b_inf)   res = {sgn, 8'hFF, 23'b0};
        else if (a_zero || b_zero) res = {sgn, 31'b0};
        return res;
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x, y;
        logic [7:0]  exa, eya, d;
        logic [23:0] mx, my;
        logic [49:0] sv;
        logic        st0;
        logic [26:0] ax, ay;
        logic [27:0] s;
        logic [4:0]  msb, lsh;
        logic [26:0] n;
        logic [8:0]  e;
        logic [7:0]  ef;
        logic        g, st, inc;
        logic [30:0] r;
        logic        a_nan, b_nan, a_inf, b_inf;
        logic [31:0] res;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        if (a[30:0] < b[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        exa = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        eya = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        mx  = {x[30:23] != 8'd0, x[22:0]};
        my  = {y[30:23] != 8'd0, y[22:0]};
        d   = exa - eya;
        if (d >= 8'd50) begin
            sv  = '0;
            st0 = |my;
        end else begin
            sv  = {my, 26'b0} >> d;
            st0 = |sv[23:0];
        end
        ay = {sv[49:24], st0};
        ax = {mx, 3'b0};
        if (x[31] == y[31]) s = {1'b0, ax} + {1'b0, ay};
        else                s = {1'b0, ax} - {1'b0, ay};
        msb = '0;
        for (int i = 0; i < 28; i++) begin
            if (s[i]) msb = 5'(i);
        end
        e = {1'b0, exa};
        if (s[27]) begin
            n = {s[27:2], s[1] | s[0]};
            e = e + 9'd1;
        end else if (msb < 5'd26) begin
            // left normalize, stopping at the subnormal boundary
            lsh = 5'd26 - msb;
            if ({4'b0, lsh} >= e) lsh = 5'(e - 9'd1);
            n = s[26:0] << lsh;
            e = e - {4'b0, lsh};
        end else begin
            n = s[26:0];
        end
        ef  = n[26] ? e[7:0] : 8'd0;
        g   = n[2];
        st  = |n[1:0];
        inc = g & (st | n[3]);
        r   = {ef, n[25:3]} + 31'(inc);
        if (e >= 9'd255)   res = {x[31], 8'hFF, 23'b0};
        else if (s == '0)  res = FP_ZERO;
        else               res = {x[31], r};
        if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) res = FP_QNAN;
        else if (a_inf)    res = a;
        else if (b_inf)    res = b;
        else if (a[30:0] == '0 && b[30:0] == '0) res = {a[31] & b[31], 31'b0};
        return res;
    endfunction

    function automatic logic [31:0] fp_canon(input logic [31:0] v);
        if (v[30:23] == 8'hFF && v[22:0] != '0) return FP_QNAN;
        return v;
    endfunction

endpackage

// ----- hw/rtl/dqmv_front.sv -----
// Input stage: configuration registers, vector store, column/row sequencing.
// Depends on dqmv_pkg; feeds dqmv_mac through dqmv_s1_t.
module dqmv_front import dqmv_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              accept,
    input  logic              s_req_type,
    input  logic [COL_W-1:0]  s_x_index,
    input  logic [31:0]       s_x_value,
    input  logic [7:0]        s_weight_code,
    input  logic [31:0]       s_row_scale,
    input  logic [31:0]       s_row_offset,
    output dqmv_s1_t          s1
);

    logic [31:0]      vec_mem [MAX_COLUMNS];
    logic [11:0]      cols_reg;
    logic [15:0]      rows_reg;
    logic [15:0]      first_reg;
    logic [COL_W-1:0] col_reg;
    logic [15:0]      row_reg;
    logic [31:0]      x_reg;
    logic             vld_reg, clr_reg, fin_reg, last_reg;
    logic [7:0]       biased_reg;
    logic [31:0]      scale_reg, offset_reg;
    logic [15:0]      rnum_reg;
    logic [11:0]      cols_eff;
    logic [15:0]      rows_eff;
    logic             col_end, row_last;

    always_comb begin
        if (cols_reg == 12'd0)                     cols_eff = 12'd1;
        else if (cols_reg > 12'(MAX_COLUMNS))      cols_eff = 12'(MAX_COLUMNS);
        else                                       cols_eff = cols_reg;
        rows_eff = (rows_reg == 16'd0) ? 16'd1 : rows_reg;
        col_end  = (12'(col_reg) + 12'd1) >= cols_eff;
        row_last = ({1'b0, row_reg} + 17'd1) >= {1'b0, rows_eff};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg  <= 12'd2048;
            rows_reg  <= 16'd1;
            first_reg <= 16'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COLUMNS:   cols_reg  <= cfg_data[11:0];
                REG_ROWS:      rows_reg  <= cfg_data;
                REG_FIRST_ROW: first_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_req_type == REQ_LOAD) vec_mem[s_x_index] <= s_x_value;
        if (accept) x_reg <= vec_mem[col_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            vld_reg <= 1'b0;
            clr_reg <= 1'b0;
            fin_reg <= 1'b0;
        end else begin
            vld_reg <= accept && s_req_type == REQ_WEIGHT;
            clr_reg <= accept && s_req_type == REQ_LOAD;
            fin_reg <= accept && s_req_type == REQ_WEIGHT && col_end;
            if (accept) begin
                if (s_req_type == REQ_LOAD) begin
                    col_reg <= '0;
                    row_reg <= '0;
                end else if (col_end) begin
                    col_reg <= '0;
                    row_reg <= row_last ? 16'd0 : row_reg + 16'd1;
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            biased_reg <= s_weight_code ^ CODE_BIAS;
            scale_reg  <= s_row_scale;
            offset_reg <= s_row_offset;
            rnum_reg   <= first_reg + row_reg;
            last_reg   <= row_last;
        end
    end

    assign s1.vld    = vld_reg;
    assign s1.clr    = clr_reg;
    assign s1.fin    = fin_reg;
    assign s1.biased = biased_reg;
    assign s1.x      = x_reg;
    assign s1.scale  = scale_reg;
    assign s1.offset = offset_reg;
    assign s1.rnum   = rnum_reg;
    assign s1.last   = last_reg;

endmodule

// ----- hw/rtl/dqmv_mac.sv -----
// Product stage and loop-carried dot/sum accumulators.
// Depends on dqmv_pkg; takes dqmv_s1_t, hands finished rows out as dqmv_end_t.
module dqmv_mac import dqmv_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  dqmv_s1_t   s1,
    output dqmv_end_t  row_end,
    output logic [1:0] pend
);

    logic        p_vld_reg, p_clr_reg, p_fin_reg, p_last_reg;
    logic [31:0] prod_reg, px_reg, p_scale_reg, p_offset_reg;
    logic [15:0] p_rnum_reg;
    logic [31:0] dot_reg, sum_reg;
    logic [31:0] dot_next, sum_next;
    dqmv_end_t   end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
            p_clr_reg <= 1'b0;
            p_fin_reg <= 1'b0;
        end else begin
            p_vld_reg <= s1.vld;
            p_clr_reg <= s1.clr;
            p_fin_reg <= s1.fin;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= fp_mul(u8_to_fp(s1.biased), s1.x);
        px_reg       <= s1.x;
        p_scale_reg  <= s1.scale;
        p_offset_reg <= s1.offset;
        p_rnum_reg   <= s1.rnum;
        p_last_reg   <= s1.last;
    end

    assign dot_next = fp_add(dot_reg, prod_reg);
    assign sum_next = fp_add(sum_reg, px_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg     <= FP_ZERO;
            sum_reg     <= FP_ZERO;
            end_reg.vld <= 1'b0;
        end else begin
            end_reg.vld    <= p_vld_reg && p_fin_reg;
            end_reg.dot    <= dot_next;
            end_reg.sum    <= sum_next;
            end_reg.scale  <= p_scale_reg;
            end_reg.offset <= p_offset_reg;
            end_reg.rnum   <= p_rnum_reg;
            end_reg.last   <= p_last_reg;
            if (p_clr_reg || (p_vld_reg && p_fin_reg)) begin
                dot_reg <= FP_ZERO;
                sum_reg <= FP_ZERO;
            end else if (p_vld_reg) begin
                dot_reg <= dot_next;
                sum_reg <= sum_next;
            end
        end
    end

    assign row_end = end_reg;
    assign pend    = {1'b0, p_vld_reg && p_fin_reg} + {1'b0, end_reg.vld};

endmodule

// ----- hw/rtl/dqmv_out.sv -----
// Row result stage: scale/offset products, final add, result queue.
// Depends on dqmv_pkg; drives the m_ channel of the top level.
module dqmv_out import dqmv_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  dqmv_end_t           row_end,
    output logic [OUTQ_PTR_W:0] held,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [31:0]         m_row_value,
    output logic [15:0]         m_row_number,
    output logic                m_last_row
);

    logic                  t_vld_reg, t_last_reg;
    logic [31:0]           t1_reg, t2_reg;
    logic [15:0]           t_rnum_reg;
    logic [48:0]           q_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_reg, rd_reg;
    logic [OUTQ_PTR_W:0]   cnt_reg;
    logic                  pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) t_vld_reg <= 1'b0;
        else          t_vld_reg <= row_end.vld;
    end

    always_ff @(posedge aclk) begin
        t1_reg     <= fp_mul(row_end.scale, row_end.dot);
        t2_reg     <= fp_mul(row_end.offset, row_end.sum);
        t_rnum_reg <= row_end.rnum;
        t_last_reg <= row_end.last;
    end

    assign pop = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (t_vld_reg) q_mem[wr_reg] <= {fp_canon(fp_add(t1_reg, t2_reg)), t_rnum_reg, t_last_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (t_vld_reg) wr_reg <= wr_reg + 1'b1;
            if (pop)       rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (OUTQ_PTR_W+1)'(t_vld_reg) - (OUTQ_PTR_W+1)'(pop);
        end
    end

    assign m_valid      = cnt_reg != '0;
    assign m_row_value  = q_mem[rd_reg][48:17];
    assign m_row_number = q_mem[rd_reg][16:1];
    assign m_last_row   = q_mem[rd_reg][0];
    assign held         = cnt_reg + (OUTQ_PTR_W+1)'(t_vld_reg);

endmodule

// ----- hw/rtl/int8_dequant_matvec_row.sv -----
// Top level of the int8 dequant matvec row block: front, MAC and output stages.
// Depends on dqmv_pkg, dqmv_front, dqmv_mac, dqmv_out.
//
//  port group  direction  moves
//  s_*         in         vector load (req_type 0) or one weight code (req_type 1)
//  m_*         out        one finished row: value, row number, last-row flag
//  cfg_*       in         register write, no handshake
//
// One item per cycle while s_ready is high. A row result is written into the result queue
// through the store read, the code product, the accumulator add, the scale/offset
// products and the final add, one register stage each.
// s_ready drops only when the 8-entry result queue plus rows in flight would overflow.
// Synchronous active-low reset clears counters, accumulators and the queue; the
// vector store keeps its contents.
module int8_dequant_matvec_row import dqmv_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_req_type,
    input  logic [COL_W-1:0] s_x_index,
    input  logic [31:0]      s_x_value,
    input  logic signed [7:0] s_weight_code,
    input  logic [31:0]      s_row_scale,
    input  logic [31:0]      s_row_offset,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [31:0]      m_row_value,
    output logic [15:0]      m_row_number,
    output logic             m_last_row
);

    dqmv_s1_t            s1;
    dqmv_end_t           row_end;
    logic [1:0]          pend;
    logic [OUTQ_PTR_W:0] held;
    logic [OUTQ_PTR_W+1:0] committed;
    logic                accept;

    assign committed = (OUTQ_PTR_W+2)'(s1.fin) + (OUTQ_PTR_W+2)'(pend)
                       + (OUTQ_PTR_W+2)'(held);
    assign s_ready   = committed < (OUTQ_PTR_W+2)'(OUTQ_DEPTH);
    assign accept    = s_valid && s_ready;

    dqmv_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .s_req_type    (s_req_type),
        .s_x_index     (s_x_index),
        .s_x_value     (s_x_value),
        .s_weight_code (s_weight_code),
        .s_row_scale   (s_row_scale),
        .s_row_offset  (s_row_offset),
        .s1            (s1)
    );

    dqmv_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s1      (s1),
        .row_end (row_end),
        .pend    (pend)
    );

    dqmv_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .row_end      (row_end),
        .held         (held),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_value  (m_row_value),
        .m_row_number (m_row_number),
        .m_last_row   (m_last_row)
    );

endmodule

// ----- hw/rtl/dqmv_checker.sv -----
// Port-level checks for int8_dequant_matvec_row, attached by bind.
// Depends on dqmv_pkg.
module dqmv_checker import dqmv_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             s_req_type,
    input logic             m_valid,
    input logic             m_ready,
    input logic [31:0]      m_row_value,
    input logic [15:0]      m_row_number,
    input logic             m_last_row
);

    // a result held back keeps its valid
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped before the item was taken");

    // a held result keeps its payload
    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_row_value) && $stable(m_row_number)
                                 && $stable(m_last_row))
        else $error("result payload changed while stalled");

    // an empty queue fills only from an earlier accepted weight item
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_req_type == REQ_WEIGHT, 5))
        else $error("result appeared without a matching weight item");

    // input stalls only when results are backed up
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with nothing waiting at the output");

endmodule

bind int8_dequant_matvec_row dqmv_checker u_dqmv_checker (.*);

// ----- verif/tb_int8_dequant_matvec_row.sv -----
// Self-checking testbench for int8_dequant_matvec_row: bit-exact float32 row predictor,
// valid/ready driver and monitor with random bursts and stalls.
// Depends on dqmv_pkg and the int8_dequant_matvec_row RTL.
module tb_int8_dequant_matvec_row;
    import dqmv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic              req;
        logic [10:0]       idx;
        logic [31:0]       xval;
        logic signed [7:0] code;
        logic [31:0]       scale;
        logic [31:0]       offset;
    } matvec_item_t;

    typedef struct {
        logic [31:0] value;
        logic [15:0] number;
        logic        last;
    } row_result_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [1:0]        cfg_index;
    logic [15:0]       cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic              s_req_type;
    logic [10:0]       s_x_index;
    logic [31:0]       s_x_value;
    logic signed [7:0] s_weight_code;
    logic [31:0]       s_row_scale;
    logic [31:0]       s_row_offset;
    logic              m_valid;
    logic              m_ready;
    logic [31:0]       m_row_value;
    logic [15:0]       m_row_number;
    logic              m_last_row;

    int8_dequant_matvec_row dut (.*);

    matvec_item_t pending_items[$];
    row_result_t  expected_rows[$];

    // predictor state
    logic [31:0] vec_mem [MAX_COLUMNS];
    logic [31:0] dot_acc, xsum_acc;
    int unsigned col_cnt, row_cnt;
    logic [11:0] cols_reg;
    logic [15:0] rows_reg, first_reg;

    int errors, rows_checked, items_taken, queued_items;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #30ms;
        $display("int8_dequant_matvec_row verification failed");
        $finish;
    end

    // value = m * 2^e, rounded to nearest even into binary32
    function automatic logic [31:0] fp_round(logic sgn, logic [127:0] m, int e);
        int k, sh, ex, biased;
        logic [127:0] kept, rem, half;
        k = 0;
        for (int i = 0; i < 128; i++) if (m[i]) k = i;
        sh = k - 23;
        if (sh < -149 - e) sh = -149 - e;
        if (sh > 100) begin
            kept = '0;
        end else if (sh > 0) begin
            kept = m >> sh;
            rem  = m & ((128'd1 << sh) - 1);
            half = 128'd1 << (sh - 1);
            if (rem > half || (rem == half && kept[0])) kept = kept + 1;
        end else begin
            kept = m << (-sh);
        end
        ex = sh + e;
        if (kept[24]) begin
            kept = kept >> 1;
            ex++;
        end
        if (!kept[23]) return {sgn, 8'd0, kept[22:0]};
        biased = ex + 23 + 127;
        if (biased >= 255) return {sgn, 8'hFF, 23'd0};
        return {sgn, 8'(biased), kept[22:0]};
    endfunction

    function automatic logic is_nan(logic [31:0] v);
        return v[30:23] == 8'hFF && v[22:0] != '0;
    endfunction

    function automatic logic is_inf(logic [31:0] v);
        return v[30:23] == 8'hFF && v[22:0] == '0;
    endfunction

    function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
        logic sgn;
        int ea, eb;
        sgn = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return FP_QNAN;
        if ((is_inf(a) && b[30:0] == '0) || (is_inf(b) && a[30:0] == '0)) return FP_QNAN;
        if (is_inf(a) || is_inf(b)) return {sgn, 8'hFF, 23'd0};
        if (a[30:0] == '0 || b[30:0] == '0) return {sgn, 31'd0};
        ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
        return fp_round(sgn, 128'({a[30:23] != 0, a[22:0]}) * 128'({b[30:23] != 0, b[22:0]}),
                        ea + eb - 300);
    endfunction

    function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
        logic [31:0] x, y;
        int ex, ey, d;
        logic [127:0] mx, my, sum;
        if (is_nan(a) || is_nan(b)) return FP_QNAN;
        if (is_inf(a) && is_inf(b) && a[31] != b[31]) return FP_QNAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (a[30:0] == '0 && b[30:0] == '0) return {a[31] & b[31], 31'd0};
        if (a[30:0] < b[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        ex = (x[30:23] == 0) ? 1 : int'(x[30:23]);
        ey = (y[30:23] == 0) ? 1 : int'(y[30:23]);
        d  = ex - ey;
        mx = 128'({x[30:23] != 0, x[22:0]}) << 42;
        my = 128'({y[30:23] != 0, y[22:0]});
        // far below the guard bit the smaller operand only matters as sticky
        if (d <= 42) my = my << (42 - d);
        else         my = (my != 0) ? 128'd1 : 128'd0;
        sum = (x[31] == y[31]) ? mx + my : mx - my;
        if (sum == 0) return FP_ZERO;
        return fp_round(x[31], sum, ex - 150 - 42);
    endfunction

    task automatic predict_item(matvec_item_t it);
        int unsigned cols, rows, col;
        logic [7:0]  biased;
        logic [31:0] xv, wf, y;
        row_result_t r;
        if (it.req == REQ_LOAD) begin
            vec_mem[it.idx] = it.xval;
            dot_acc  = FP_ZERO;
            xsum_acc = FP_ZERO;
            col_cnt  = 0;
            row_cnt  = 0;
            return;
        end
        cols = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLUMNS ? MAX_COLUMNS : cols_reg);
        rows = (rows_reg == 0) ? 1 : rows_reg;
        col  = (col_cnt >= MAX_COLUMNS) ? MAX_COLUMNS - 1 : col_cnt;
        biased = it.code ^ CODE_BIAS;
        wf = (biased == 0) ? FP_ZERO : fp_round(1'b0, 128'(biased), 0);
        xv = vec_mem[col];
        dot_acc  = f32_add(dot_acc, f32_mul(wf, xv));
        xsum_acc = f32_add(xsum_acc, xv);
        if (col_cnt + 1 < cols) begin
            col_cnt++;
            return;
        end
        y = f32_add(f32_mul(it.scale, dot_acc), f32_mul(it.offset, xsum_acc));
        r.value  = is_nan(y) ? FP_QNAN : y;
        r.number = 16'(first_reg + row_cnt);
        r.last   = (row_cnt + 1 >= rows);
        expected_rows.push_back(r);
        row_cnt  = r.last ? 0 : ((row_cnt + 1) & 16'hFFFF);
        dot_acc  = FP_ZERO;
        xsum_acc = FP_ZERO;
        col_cnt  = 0;
    endtask

    // driver: bursts of random length separated by random gaps
    int burst_left, gap_left;
    always @(posedge aclk) begin
        matvec_item_t it;
        logic next_valid;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                it.req = s_req_type; it.idx = s_x_index; it.xval = s_x_value;
                it.code = s_weight_code; it.scale = s_row_scale; it.offset = s_row_offset;
                predict_item(it);
                items_taken++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    s_req_type    <= it.req;
                    s_x_index     <= it.idx;
                    s_x_value     <= it.xval;
                    s_weight_code <= it.code;
                    s_row_scale   <= it.scale;
                    s_row_offset  <= it.offset;
                    next_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_valid <= next_valid;
        end
    end

    // monitor: ready pattern switches mode every so often
    int stall_mode, mode_cycles;
    always @(posedge aclk) begin
        row_result_t e;
        if (!aresetn) begin
            m_ready     <= 1'b0;
            stall_mode  <= 0;
            mode_cycles <= 0;
        end else begin
            if (m_valid && m_ready) begin
                rows_checked++;
                if (expected_rows.size() == 0) begin
                    $error("row result with nothing expected: value %h number %0d",
                           m_row_value, m_row_number);
                    errors++;
                end else begin
                    e = expected_rows.pop_front();
                    if (m_row_value !== e.value) begin
                        $error("row_value expected %h actual %h", e.value, m_row_value);
                        errors++;
                    end
                    if (m_row_number !== e.number) begin
                        $error("row_number expected %0d actual %0d", e.number, m_row_number);
                        errors++;
                    end
                    if (m_last_row !== e.last) begin
                        $error("last_row expected %0b actual %0b", e.last, m_last_row);
                        errors++;
                    end
                end
            end
            if (mode_cycles == 0) begin
                stall_mode  <= $urandom_range(0, 3);
                mode_cycles <= $urandom_range(20, 300);
            end else begin
                mode_cycles <= mode_cycles - 1;
            end
            case (stall_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= $urandom_range(0, 1);
                2:       m_ready <= ($urandom_range(0, 7) == 0);
                default: m_ready <= (mode_cycles % 16) < 12;
            endcase
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_rows.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_regs(logic [11:0] cols, logic [15:0] rows, logic [15:0] first);
        @(posedge aclk);
        cfg_wr_en <= 1'b1; cfg_index <= REG_COLUMNS;   cfg_data <= 16'(cols);
        @(posedge aclk);
        cfg_index <= REG_ROWS;      cfg_data <= rows;
        @(posedge aclk);
        cfg_index <= REG_FIRST_ROW; cfg_data <= first;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cols_reg  = cols;
        rows_reg  = rows;
        first_reg = first;
    endtask

    function automatic logic [31:0] rand_float();
        case ($urandom_range(0, 19))
            0:       return $urandom;
            1:       return {1'($urandom), 8'($urandom_range(0, 2)), 23'($urandom)};
            default: return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
        endcase
    endfunction

    task automatic push_load(int idx, logic [31:0] v);
        matvec_item_t it;
        it.req = REQ_LOAD; it.idx = 11'(idx); it.xval = v;
        it.code = 8'($urandom); it.scale = $urandom; it.offset = $urandom;
        pending_items.push_back(it);
    endtask

    task automatic push_weight(logic [7:0] code, logic [31:0] sc, logic [31:0] off);
        matvec_item_t it;
        it.req = REQ_WEIGHT; it.idx = 11'($urandom); it.xval = $urandom;
        it.code = code; it.scale = sc; it.offset = off;
        pending_items.push_back(it);
    endtask

    // loads entries 0..n-1 in shuffled order
    task automatic load_vector(int n);
        int perm[];
        int j, t;
        perm = new[n];
        for (int i = 0; i < n; i++) perm[i] = i;
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i]; perm[i] = perm[j]; perm[j] = t;
        end
        for (int i = 0; i < n; i++) push_load(perm[i], rand_float());
    endtask

    initial begin
        int n_cols, n_weights, phases;
        logic [11:0] c;
        logic [15:0] r, f;
        errors = 0; rows_checked = 0; items_taken = 0; queued_items = 0;
        aresetn = 1'b0; cfg_wr_en = 1'b0; cfg_index = REG_COLUMNS; cfg_data = '0;
        s_valid = 1'b0; s_req_type = REQ_LOAD; s_x_index = '0; s_x_value = '0;
        s_weight_code = '0; s_row_scale = '0; s_row_offset = '0; m_ready = 1'b0;
        dot_acc = FP_ZERO; xsum_acc = FP_ZERO; col_cnt = 0; row_cnt = 0;
        cols_reg = 12'd2048; rows_reg = 16'd1; first_reg = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: operand extremes and special scales, row-number wrap
        write_regs(12'd4, 16'd2, 16'hFFFF);
        push_load(0, 32'h0000_0001);
        push_load(1, 32'h7F7F_FFFF);
        push_load(2, 32'h8000_0000);
        push_load(3, 32'h3F80_0000);
        push_weight(8'h80, 32'h0, 32'h0);
        push_weight(8'h7F, 32'h0, 32'h0);
        push_weight(8'h00, 32'h0, 32'h0);
        push_weight(8'hFF, 32'h7F80_0000, 32'h0000_0000);
        push_weight(8'h7F, 32'h0, 32'h0);
        push_weight(8'h7F, 32'h0, 32'h0);
        push_load(3, 32'hBF80_0000);      // reload mid-row abandons the row
        push_weight(8'h01, 32'h0, 32'h0);
        push_weight(8'h80, 32'h0, 32'h0);
        push_weight(8'h00, 32'h0, 32'h0);
        push_weight(8'h7F, 32'hFFC1_2345, 32'h3F80_0000);
        push_weight(8'h10, 32'h0, 32'h0);
        push_weight(8'h20, 32'h0, 32'h0);
        push_weight(8'h30, 32'h0, 32'h0);
        push_weight(8'h40, 32'h0000_0001, 32'hFF7F_FFFF);
        queued_items = 19;
        wait_drained();

        phases = 0;
        while (queued_items < 1200) begin
            case ($urandom_range(0, 9))
                0:       c = 12'd0;
                1:       c = 12'd1;
                2:       c = 12'($urandom_range(25, 96));
                default: c = 12'($urandom_range(1, 24));
            endcase
            case ($urandom_range(0, 5))
                0:       r = 16'd0;
                1:       r = 16'd1;
                2:       r = 16'hFFFF;
                default: r = 16'($urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 3))
                0:       f = 16'd0;
                1:       f = 16'hFFFF;
                default: f = 16'($urandom);
            endcase
            n_cols = (c == 0) ? 1 : (c > MAX_COLUMNS ? MAX_COLUMNS : c);
            n_weights = (n_cols > 64) ? n_cols + $urandom_range(0, 8)
                                      : $urandom_range(40, 150);
            wait_drained();
            write_regs(c, r, f);
            load_vector(n_cols);
            for (int i = 0; i < n_weights; i++) begin
                if ($urandom_range(0, 99) < 2)
                    push_load($urandom_range(0, n_cols - 1), rand_float());
                else
                    push_weight(8'($urandom), rand_float(), rand_float());
            end
            queued_items += n_cols + n_weights;
            phases++;
        end
        wait_drained();
        repeat (20) @(posedge aclk);

        $display("%0d items taken over %0d register settings, %0d row results checked",
                 items_taken, phases + 1, rows_checked);
        if (errors == 0 && expected_rows.size() == 0)
            $display("int8_dequant_matvec_row verification clean");
        else
            $display("int8_dequant_matvec_row verification failed");
        $finish;
    end
endmodule
